FILE: src/angular_occlusion_range_set_defines.svh
// assertion macros used by the checker file
`ifndef ANGULAR_OCCLUSION_RANGE_SET_DEFINES_SVH
`define ANGULAR_OCCLUSION_RANGE_SET_DEFINES_SVH

// condition must hold in the cycle after the trigger
`define AORS_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

// condition must hold in the same cycle as the trigger
`define AORS_ASSERT_SAME(lbl, clk, rst_n, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

`endif

FILE: src/aors_pkg.sv
`default_nettype none
package aors_pkg;

	localparam int MAX_RANGES_DEF = 128;
	localparam int ANGLE_BITS_DEF = 16;

	// request codes
	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_ADD   = 2'd1,
		REQ_RANGE = 2'd2,
		REQ_ANGLE = 2'd3
	} req_t;

	// command broadcast to every cell
	typedef enum logic [2:0] {
		CMD_HOLD  = 3'd0,
		CMD_DROP  = 3'd1,
		CMD_MERGE = 3'd2,
		CMD_SETHI = 3'd3,
		CMD_SETLO = 3'd4,
		CMD_INS   = 3'd5
	} cell_cmd_t;

	// compare results of one cell
	typedef struct packed {
		logic contained;
		logic covered;
		logic hi_in;
		logic merge;
		logic lo_in;
		logic interior;
		logic ge_end;
	} cell_flags_t;

endpackage
`default_nettype wire

FILE: src/aors_req_if.sv
`default_nettype none
interface aors_req_if #(
	parameter int ANGLE_BITS = aors_pkg::ANGLE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	aors_pkg::req_t        req_type;
	logic [ANGLE_BITS-1:0] start_angle;
	logic [ANGLE_BITS-1:0] end_angle;

	modport source (output valid, req_type, start_angle, end_angle, input ready);
	modport sink (input valid, req_type, start_angle, end_angle, output ready);
endinterface
`default_nettype wire

FILE: src/aors_res_if.sv
`default_nettype none
interface aors_res_if;
	logic valid;
	logic ready;
	logic visible;
	logic overflow;

	modport source (output valid, visible, overflow, input ready);
	modport sink (input valid, visible, overflow, output ready);
endinterface
`default_nettype wire

FILE: src/aors_cell.sv
`default_nettype none
module aors_cell #(
	parameter int ANGLE_BITS = aors_pkg::ANGLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire aors_pkg::cell_cmd_t   cmd,
	input  wire logic [ANGLE_BITS-1:0] part_s,
	input  wire logic [ANGLE_BITS-1:0] part_e,
	input  wire logic                  valid,
	input  wire logic                  next_valid,
	input  wire logic [ANGLE_BITS-1:0] next_lo,
	input  wire logic [ANGLE_BITS-1:0] next_hi,
	input  wire logic [ANGLE_BITS-1:0] prev_lo,
	input  wire logic [ANGLE_BITS-1:0] prev_hi,
	input  wire logic                  prev_shift,
	input  wire logic                  prev_ok,
	output logic [ANGLE_BITS-1:0]      lo,
	output logic [ANGLE_BITS-1:0]      hi,
	output aors_pkg::cell_flags_t      flags
);

	logic [ANGLE_BITS-1:0] lo_q;
	logic [ANGLE_BITS-1:0] hi_q;
	logic                  shl;

	assign lo = lo_q;
	assign hi = hi_q;

	// compares against the broadcast part
	always_comb begin
		flags.contained = valid && (lo_q >= part_s) && (hi_q <= part_e);
		flags.covered   = valid && (part_s >= lo_q) && (part_e <= hi_q);
		flags.hi_in     = valid && (hi_q >= part_s) && (hi_q <= part_e);
		flags.merge     = flags.hi_in && next_valid && (next_lo <= part_e);
		flags.lo_in     = valid && (lo_q >= part_s) && (lo_q <= part_e);
		flags.interior  = valid && (part_s > lo_q) && (part_s < hi_q);
		flags.ge_end    = valid && (lo_q >= part_e);
		shl             = valid && (lo_q >= part_s);
	end

	// entry update
	always_ff @(posedge clk) begin
		case (cmd)
			aors_pkg::CMD_DROP: begin
				if (shl) begin
					lo_q <= next_lo;
					hi_q <= next_hi;
				end
			end
			aors_pkg::CMD_MERGE: begin
				if (flags.merge) begin
					hi_q <= next_hi;
				end else if (shl) begin
					lo_q <= next_lo;
					hi_q <= next_hi;
				end
			end
			aors_pkg::CMD_SETHI: begin
				if (flags.hi_in) hi_q <= part_e;
			end
			aors_pkg::CMD_SETLO: begin
				if (flags.lo_in) lo_q <= part_s;
			end
			aors_pkg::CMD_INS: begin
				if (prev_shift) begin
					lo_q <= prev_lo;
					hi_q <= prev_hi;
				end else if (prev_ok && (!valid || flags.ge_end)) begin
					lo_q <= part_s;
					hi_q <= part_e;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: src/angular_occlusion_range_set.sv
// sequence: an accepted item is registered; clear and rejected items go straight to the
// result stage, while checks and adds take one step of the cell row per part (a wrapping
// range is split into two parts), adds one further step per stored range lying inside the
// part, an add equal to a stored range counting as one; the result register is then loaded
// issue: the next item is taken once the result is loaded, later while a held result waits
// reset: arst_n empties the set at once; no clearing pass, the store contents stay undefined
`default_nettype none
module angular_occlusion_range_set #(
	parameter int MAX_RANGES = aors_pkg::MAX_RANGES_DEF,
	parameter int ANGLE_BITS = aors_pkg::ANGLE_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	aors_req_if.sink   req,
	aors_res_if.source res
);

	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam logic [ANGLE_BITS-1:0] ANG_MAX  = '1;
	localparam logic [ANGLE_BITS-1:0] ANG_HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_RANGES);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                state_q;
	aors_pkg::req_t        req_q;
	logic [ANGLE_BITS-1:0] ps_q;
	logic [ANGLE_BITS-1:0] pe_q;
	logic [ANGLE_BITS-1:0] e_q;
	logic                  second_q;
	logic                  vis_q;
	logic                  ovf_q;
	logic [CW-1:0]         count_q;
	logic                  res_valid_q;
	logic                  res_vis_q;
	logic                  res_ovf_q;

	logic [ANGLE_BITS-1:0] lo_w [MAX_RANGES];
	logic [ANGLE_BITS-1:0] hi_w [MAX_RANGES];
	aors_pkg::cell_flags_t flags_w [MAX_RANGES];
	logic                  valid_w [MAX_RANGES];

	aors_pkg::cell_cmd_t   cmd;
	logic                  part_done;
	logic                  vis_set;
	logic                  vis_clr;
	logic                  ovf_set;
	logic                  cnt_inc;
	logic                  cnt_dec;
	logic                  any_contained;
	logic                  any_covered;
	logic                  any_hi_in;
	logic                  any_merge;
	logic                  any_lo_in;
	logic                  any_interior;
	logic                  accept;
	logic                  out_load;
	logic [ANGLE_BITS-1:0] in_len;
	logic                  in_wrap;
	logic                  in_run;

	// row of entry cells
	for (genvar j = 0; j < MAX_RANGES; j++) begin : g_cell
		logic                  nv;
		logic [ANGLE_BITS-1:0] nlo;
		logic [ANGLE_BITS-1:0] nhi;
		logic [ANGLE_BITS-1:0] plo;
		logic [ANGLE_BITS-1:0] phi;
		logic                  psh;
		logic                  pok;

		assign valid_w[j] = CW'(j) < count_q;

		if (j == MAX_RANGES - 1) begin : g_last
			assign nv  = 1'b0;
			assign nlo = lo_w[j];
			assign nhi = hi_w[j];
		end else begin : g_mid
			assign nv  = valid_w[j+1];
			assign nlo = lo_w[j+1];
			assign nhi = hi_w[j+1];
		end

		if (j == 0) begin : g_first
			assign plo = lo_w[j];
			assign phi = hi_w[j];
			assign psh = 1'b0;
			assign pok = 1'b1;
		end else begin : g_rest
			assign plo = lo_w[j-1];
			assign phi = hi_w[j-1];
			assign psh = flags_w[j-1].ge_end;
			assign pok = valid_w[j-1] && !flags_w[j-1].ge_end;
		end

		aors_cell #(
			.ANGLE_BITS(ANGLE_BITS)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.part_s    (ps_q),
			.part_e    (pe_q),
			.valid     (valid_w[j]),
			.next_valid(nv),
			.next_lo   (nlo),
			.next_hi   (nhi),
			.prev_lo   (plo),
			.prev_hi   (phi),
			.prev_shift(psh),
			.prev_ok   (pok),
			.lo        (lo_w[j]),
			.hi        (hi_w[j]),
			.flags     (flags_w[j])
		);
	end

	// or of the cell flags
	always_comb begin
		any_contained = 1'b0;
		any_covered   = 1'b0;
		any_hi_in     = 1'b0;
		any_merge     = 1'b0;
		any_lo_in     = 1'b0;
		any_interior  = 1'b0;
		for (int i = 0; i < MAX_RANGES; i++) begin
			any_contained = any_contained | flags_w[i].contained;
			any_covered   = any_covered | flags_w[i].covered;
			any_hi_in     = any_hi_in | flags_w[i].hi_in;
			any_merge     = any_merge | flags_w[i].merge;
			any_lo_in     = any_lo_in | flags_w[i].lo_in;
			any_interior  = any_interior | flags_w[i].interior;
		end
	end

	// one step of the current part
	always_comb begin
		cmd       = aors_pkg::CMD_HOLD;
		part_done = 1'b0;
		vis_set   = 1'b0;
		vis_clr   = 1'b0;
		ovf_set   = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		if (state_q == ST_RUN) begin
			case (req_q)
				aors_pkg::REQ_ADD: begin
					if (ps_q == pe_q) begin
						part_done = 1'b1;
					end else if (any_contained) begin
						cmd     = aors_pkg::CMD_DROP;
						cnt_dec = 1'b1;
					end else if (any_covered) begin
						part_done = 1'b1;
					end else if (any_hi_in) begin
						part_done = 1'b1;
						if (any_merge) begin
							cmd     = aors_pkg::CMD_MERGE;
							cnt_dec = 1'b1;
						end else begin
							cmd = aors_pkg::CMD_SETHI;
						end
					end else if (any_lo_in) begin
						cmd       = aors_pkg::CMD_SETLO;
						part_done = 1'b1;
					end else if (count_q == CNT_FULL) begin
						ovf_set   = 1'b1;
						part_done = 1'b1;
					end else begin
						cmd       = aors_pkg::CMD_INS;
						cnt_inc   = 1'b1;
						part_done = 1'b1;
					end
				end
				aors_pkg::REQ_RANGE: begin
					vis_set   = !any_covered;
					part_done = 1'b1;
				end
				aors_pkg::REQ_ANGLE: begin
					vis_set   = !any_interior;
					vis_clr   = any_interior;
					part_done = 1'b1;
				end
				default: begin
					part_done = 1'b1;
				end
			endcase
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_len    = req.end_angle - req.start_angle;
	assign in_wrap   = req.end_angle < req.start_angle;
	assign out_load  = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	// whether an accepted item needs the cell row
	always_comb begin
		case (req.req_type)
			aors_pkg::REQ_ADD:   in_run = (in_len != '0) && (in_len <= ANG_HALF);
			aors_pkg::REQ_RANGE: in_run = (in_len != '0) && (in_len < ANG_HALF);
			aors_pkg::REQ_ANGLE: in_run = 1'b1;
			default:             in_run = 1'b0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			second_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q    <= req.req_type;
						e_q      <= req.end_angle;
						ps_q     <= req.start_angle;
						pe_q     <= in_wrap ? ANG_MAX : req.end_angle;
						second_q <= in_wrap && (req.req_type != aors_pkg::REQ_ANGLE);
						vis_q    <= 1'b0;
						ovf_q    <= 1'b0;
						state_q  <= in_run ? ST_RUN : ST_DONE;
						if (req.req_type == aors_pkg::REQ_CLEAR) count_q <= '0;
					end
				end
				ST_RUN: begin
					if (cnt_inc) count_q <= count_q + CW'(1);
					if (cnt_dec) count_q <= count_q - CW'(1);
					if (vis_set) vis_q <= 1'b1;
					if (vis_clr) vis_q <= 1'b0;
					if (ovf_set) ovf_q <= 1'b1;
					if (part_done) begin
						if (second_q) begin
							ps_q     <= '0;
							pe_q     <= e_q;
							second_q <= 1'b0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_vis_q <= vis_q;
			res_ovf_q <= ovf_q;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.visible  = res_vis_q;
	assign res.overflow = res_ovf_q;

endmodule
`default_nettype wire

FILE: src/aors_checker.sv
`default_nettype none
`include "angular_occlusion_range_set_defines.svh"
module aors_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic visible,
	input wire logic overflow
);

	// a stalled result stays offered
	`AORS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped")
	// a stalled result keeps its payload
	`AORS_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(visible) && $stable(overflow), "result changed")
	// only adds flag overflow, and adds never report visible
	`AORS_ASSERT_SAME(a_flags_excl, clk, arst_n, res_valid, !(visible && overflow), "visible with overflow")
	// one item at a time through the cell row
	`AORS_ASSERT_NEXT(a_busy, clk, arst_n, req_valid && req_ready, !req_ready, "ready while busy")

endmodule

bind angular_occlusion_range_set aors_checker u_aors_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.visible  (res.visible),
	.overflow (res.overflow)
);
`default_nettype wire
